@@ hw/rtl/dsnp_pkg.sv @@
// Shared types, character codes and constant helpers for the decimal number parser.
package dsnp_pkg;

  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_POINT   = 8'h2E;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_UPPER_E = 8'h45;
  localparam logic [7:0] CHAR_LOWER_E = 8'h65;

  localparam int unsigned SigWidth = 60;
  localparam int unsigned ExpWidth = 16;

  typedef struct packed {
    logic                       negative;
    logic [SigWidth-1:0]        significand;
    logic signed [ExpWidth-1:0] decimal_exponent;
    logic                       inexact;
  } result_t;

  // Ten to the power n, evaluated at elaboration for the accumulator limit.
  function automatic logic [SigWidth-1:0] pow10(input int n);
    logic [SigWidth-1:0] p;
    p = SigWidth'(1);
    for (int i = 0; i < n; i++) begin
      p = SigWidth'(p * SigWidth'(10));
    end
    return p;
  endfunction

endpackage

@@ hw/rtl/dsnp_parser.sv @@
// Per-character parse state machine and result register of the decimal number parser.
module dsnp_parser
  import dsnp_pkg::*;
#(
  parameter int MAX_SIG_DIGITS    = 18,
  parameter int MAX_EXP_MAGNITUDE = 9999
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] character_i,
  input  logic       last_i,
  output result_t    result_o
);

  typedef enum logic [2:0] {
    PH_LEAD  = 3'd0,
    PH_INT   = 3'd1,
    PH_FRAC  = 3'd2,
    PH_MDONE = 3'd3,
    PH_EWS   = 3'd4,
    PH_EINT  = 3'd5,
    PH_EDONE = 3'd6
  } phase_e;

  localparam logic [SigWidth-1:0] AccLimit = pow10(MAX_SIG_DIGITS - 1);
  localparam logic [13:0]         ExpMax   = 14'(MAX_EXP_MAGNITUDE);
  localparam logic [15:0]         CountMax = 16'hFFFF;

  phase_e              phase_q, phase_d;
  logic                mant_neg_q, mant_neg_d;
  logic [SigWidth-1:0] acc_q, acc_d;
  logic [15:0]         frac_cnt_q, frac_cnt_d;
  logic [15:0]         drop_cnt_q, drop_cnt_d;
  logic                exp_neg_q, exp_neg_d;
  logic [13:0]         exp_mag_q, exp_mag_d;
  logic                lost_q, lost_d;
  result_t             result_q, result_d;

  logic        is_space, is_digit, is_sign, is_e, is_point;
  logic [3:0]  digit;
  logic        mant_digit, mant_frac, exp_digit;
  logic [17:0] exp_mul;
  logic signed [17:0] exp_sum;

  assign is_space = (character_i == CHAR_SPACE) ||
                    ((character_i >= CHAR_TAB) && (character_i <= CHAR_CR));
  assign is_digit = (character_i >= CHAR_ZERO) && (character_i <= CHAR_NINE);
  assign is_sign  = (character_i == CHAR_MINUS) || (character_i == CHAR_PLUS);
  assign is_e     = (character_i == CHAR_LOWER_E) || (character_i == CHAR_UPPER_E);
  assign is_point = (character_i == CHAR_POINT);
  // Digits sit at 0x30..0x39, so the low nibble is the digit value.
  assign digit    = is_digit ? character_i[3:0] : 4'd0;

  always_comb begin
    phase_d    = phase_q;
    mant_neg_d = mant_neg_q;
    exp_neg_d  = exp_neg_q;
    mant_digit = 1'b0;
    mant_frac  = 1'b0;
    exp_digit  = 1'b0;

    unique case (phase_q)
      PH_LEAD: begin
        if (!is_space) begin
          if (is_sign) begin
            mant_neg_d = (character_i == CHAR_MINUS);
            phase_d    = PH_INT;
          end else if (is_digit) begin
            mant_digit = 1'b1;
            phase_d    = PH_INT;
          end else if (is_point) begin
            phase_d = PH_FRAC;
          end else begin
            phase_d = is_e ? PH_EWS : PH_MDONE;
          end
        end
      end
      PH_INT: begin
        if (is_digit) begin
          mant_digit = 1'b1;
        end else if (is_point) begin
          phase_d = PH_FRAC;
        end else begin
          phase_d = is_e ? PH_EWS : PH_MDONE;
        end
      end
      PH_FRAC: begin
        if (is_digit) begin
          mant_digit = 1'b1;
          mant_frac  = 1'b1;
        end else begin
          phase_d = is_e ? PH_EWS : PH_MDONE;
        end
      end
      PH_MDONE: begin
        if (is_e) begin
          phase_d = PH_EWS;
        end
      end
      PH_EWS: begin
        if (!is_space) begin
          if (is_sign) begin
            exp_neg_d = (character_i == CHAR_MINUS);
            phase_d   = PH_EINT;
          end else if (is_digit) begin
            exp_digit = 1'b1;
            phase_d   = PH_EINT;
          end else begin
            phase_d = PH_EDONE;
          end
        end
      end
      PH_EINT: begin
        if (is_digit) begin
          exp_digit = 1'b1;
        end else begin
          phase_d = PH_EDONE;
        end
      end
      default: begin
        phase_d = PH_EDONE;
      end
    endcase
  end

  // Mantissa digit: kept while the accumulator has room, else counted if not fractional.
  always_comb begin
    acc_d      = acc_q;
    frac_cnt_d = frac_cnt_q;
    drop_cnt_d = drop_cnt_q;
    lost_d     = lost_q;
    exp_mag_d  = exp_mag_q;
    exp_mul    = 18'({4'd0, exp_mag_q} * 18'd10) + 18'(digit);

    if (mant_digit) begin
      if (acc_q < AccLimit) begin
        acc_d = (acc_q << 3) + (acc_q << 1) + SigWidth'(digit);
        if (mant_frac && (frac_cnt_q != CountMax)) begin
          frac_cnt_d = frac_cnt_q + 16'd1;
        end
      end else begin
        if (digit != 4'd0) begin
          lost_d = 1'b1;
        end
        if (!mant_frac && (drop_cnt_q != CountMax)) begin
          drop_cnt_d = drop_cnt_q + 16'd1;
        end
      end
    end

    if (exp_digit) begin
      if (exp_mul > 18'(MAX_EXP_MAGNITUDE)) begin
        exp_mag_d = ExpMax;
        lost_d    = 1'b1;
      end else begin
        exp_mag_d = exp_mul[13:0];
      end
    end
  end

  // Combined exponent from the updated state, saturated to the output width.
  always_comb begin
    exp_sum = $signed({2'b00, drop_cnt_d}) - $signed({2'b00, frac_cnt_d});
    if (exp_neg_d) begin
      exp_sum = exp_sum - $signed({4'd0, exp_mag_d});
    end else begin
      exp_sum = exp_sum + $signed({4'd0, exp_mag_d});
    end

    result_d.negative    = mant_neg_d;
    result_d.significand = acc_d;
    result_d.inexact     = lost_d;
    if (exp_sum > 18'sd32767) begin
      result_d.decimal_exponent = 16'sh7FFF;
      result_d.inexact          = 1'b1;
    end else if (exp_sum < -18'sd32768) begin
      result_d.decimal_exponent = 16'sh8000;
      result_d.inexact          = 1'b1;
    end else begin
      result_d.decimal_exponent = exp_sum[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_LEAD;
      mant_neg_q <= 1'b0;
      acc_q      <= '0;
      frac_cnt_q <= '0;
      drop_cnt_q <= '0;
      exp_neg_q  <= 1'b0;
      exp_mag_q  <= '0;
      lost_q     <= 1'b0;
      result_q   <= '0;
    end else if (take_i) begin
      if (last_i) begin
        phase_q    <= PH_LEAD;
        mant_neg_q <= 1'b0;
        acc_q      <= '0;
        frac_cnt_q <= '0;
        drop_cnt_q <= '0;
        exp_neg_q  <= 1'b0;
        exp_mag_q  <= '0;
        lost_q     <= 1'b0;
        result_q   <= result_d;
      end else begin
        phase_q    <= phase_d;
        mant_neg_q <= mant_neg_d;
        acc_q      <= acc_d;
        frac_cnt_q <= frac_cnt_d;
        drop_cnt_q <= drop_cnt_d;
        exp_neg_q  <= exp_neg_d;
        exp_mag_q  <= exp_mag_d;
        lost_q     <= lost_d;
      end
    end
  end

  assign result_o = result_q;

endmodule

@@ hw/rtl/decimal_scientific_number_parser.sv @@
// Top level of the decimal scientific-notation parser with its handshake and output stage.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i / in_stall_o character_i, last_i
//   out      output     out_valid_o / out_stall_i negative_o, significand_o,
//                                               decimal_exponent_o, inexact_o
//
// One character is taken per cycle unless stalled. The character marked last produces one
// result transaction, which appears in the output register on the cycle after acceptance.
// The per-character work is a multiply-by-ten on the digit accumulator, one compare
// against the digit limit, and the exponent sum, all ahead of the result register.
// Reset is asynchronous and active low; it empties the output stage and restarts the parse.
// The input is stalled only while a finished result waits and downstream stalls it.
module decimal_scientific_number_parser
  import dsnp_pkg::*;
#(
  // Number of significand digits kept, from 1 to 18.
  parameter int MAX_SIG_DIGITS    = 18,
  // Exponent magnitude at which the written exponent saturates, from 9 to 16383.
  parameter int MAX_EXP_MAGNITUDE = 9999
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 character_i,
  input  logic                       last_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       negative_o,
  output logic [SigWidth-1:0]        significand_o,
  output logic signed [ExpWidth-1:0] decimal_exponent_o,
  output logic                       inexact_o
);

  logic    take;
  logic    out_valid_q, out_valid_d;
  result_t result;

  // A new character may enter whenever the output register is empty or being drained.
  // Non-final characters could pass a full output stage too, but holding them keeps
  // the stall independent of the payload.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign take       = in_valid_i && !in_stall_o;

  dsnp_parser #(
    .MAX_SIG_DIGITS   (MAX_SIG_DIGITS),
    .MAX_EXP_MAGNITUDE(MAX_EXP_MAGNITUDE)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .character_i(character_i),
    .last_i     (last_i),
    .result_o   (result)
  );

  // The output holds until taken; a final character refills it in the same cycle.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (take && last_i) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign negative_o         = result.negative;
  assign significand_o      = result.significand;
  assign decimal_exponent_o = result.decimal_exponent;
  assign inexact_o          = result.inexact;

endmodule

@@ hw/rtl/dsnp_checker.sv @@
// Port-level assertions for the decimal number parser and the bind that attaches them.
module dsnp_checker
  import dsnp_pkg::*;
(
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic [7:0]                 character_i,
  input logic                       last_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic                       negative_o,
  input logic [SigWidth-1:0]        significand_o,
  input logic signed [ExpWidth-1:0] decimal_exponent_o,
  input logic                       inexact_o
);

  localparam logic [SigWidth-1:0] SigBound = pow10(18);

  logic in_take;
  assign in_take = in_valid_i && !in_stall_o;

  // A stalled result keeps its valid and its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(significand_o) &&
      $stable(decimal_exponent_o) && $stable(negative_o) && $stable(inexact_o))
    else $error("stalled result changed");

  // The input is held back only by a waiting, stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // A final character always yields a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && last_i |=> out_valid_o)
    else $error("no result after final character");

  // A result only appears after a final character was accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_take && last_i))
    else $error("result without final character");

  // The significand never reaches eighteen digits plus one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> significand_o < SigBound)
    else $error("significand out of range");

endmodule

bind decimal_scientific_number_parser dsnp_checker u_dsnp_checker (.*);
